@@ rtl/kruskal_minimum_spanning_tree_defines.svh @@
// Assertion macros shared by the kruskal_minimum_spanning_tree RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk, reset by arst_n.
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_DEFINES_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_DEFINES_SVH

// Property holds at every edge outside reset.
`define KMST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition at one edge implies a condition at the next edge.
`define KMST_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

@@ rtl/kmst_pkg.sv @@
// Package for the Kruskal spanning tree block: edge and command types, back-end states.
// Used by every module of the block except kmst_ram; depends on nothing.
package kmst_pkg;

	localparam int VERTICES_DEF = 16;
	localparam int EDGES_DEF    = 64;
	localparam int VID_W        = 4;
	localparam int WT_W         = 16;
	localparam int VC_W         = 5;
	localparam int VC_RESET     = 16;
	localparam int VC_MAX       = 16;
	localparam int RANK_W       = 3;
	localparam int RANK_MAX     = 7;
	localparam int TAKEN_W      = 4;
	localparam int QUEUE_DEPTH  = 2;

	typedef struct packed {
		logic [VID_W-1:0]       src;
		logic [VID_W-1:0]       dst;
		logic signed [WT_W-1:0] wt;
	} edge_t;

	typedef struct packed {
		edge_t e;
		logic  store;
		logic  run;
		logic  ovf;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_CLR,
		ST_SCAN,
		ST_EDGE,
		ST_FIND_A,
		ST_FIND_B,
		ST_JOIN,
		ST_JOIN2,
		ST_FLUSH
	} state_t;

endpackage

@@ rtl/kmst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the edge store and the union-find table.
module kmst_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0]   waddr,
	input  logic [W-1:0]                         wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0]   raddr,
	output logic [W-1:0]                         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/kmst_fifo.sv @@
// Two-entry command queue between the front and back ends.
// Depends on kmst_pkg for the command type.
module kmst_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kmst_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output kmst_pkg::cmd_t head,
	output logic          empty
);
	kmst_pkg::cmd_t ent_q [kmst_pkg::QUEUE_DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'(kmst_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ rtl/kmst_front.sv @@
// Front end: accepts edge words, decides store or drop, queues commands for the back end.
// Depends on kmst_pkg.
module kmst_front #(
	parameter int EDGES = kmst_pkg::EDGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [kmst_pkg::VID_W-1:0]    edge_source,
	input  logic [kmst_pkg::VID_W-1:0]    edge_target,
	input  logic signed [kmst_pkg::WT_W-1:0] edge_weight,
	input  logic                          last_edge,
	input  logic                          q_full,
	output logic                          q_push,
	output kmst_pkg::cmd_t                q_data
);
	localparam int ECW = $clog2(EDGES + 1);

	logic [ECW-1:0] cnt_q;
	logic           ovf_q;
	logic           fits;
	logic           acc;

	assign fits     = (cnt_q < ECW'(EDGES));
	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	// dropped non-last words produce no command
	assign q_push   = acc && (fits || last_edge);

	always_comb begin
		q_data       = '0;
		q_data.e.src = edge_source;
		q_data.e.dst = edge_target;
		q_data.e.wt  = edge_weight;
		q_data.store = fits;
		q_data.run   = last_edge;
		q_data.ovf   = ovf_q || !fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (acc) begin
			if (last_edge) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (fits) begin
				cnt_q <= cnt_q + ECW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end
endmodule

@@ rtl/kmst_back.sv @@
// Back end: sorted insertion into the edge store, union-find scan, result register.
// Depends on kmst_pkg, kmst_ram and the assertion macros header.
`include "kruskal_minimum_spanning_tree_defines.svh"

module kmst_back #(
	parameter int VERTICES = kmst_pkg::VERTICES_DEF,
	parameter int EDGES    = kmst_pkg::EDGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [kmst_pkg::VC_W-1:0]        vertex_count,
	input  logic                             q_empty,
	input  kmst_pkg::cmd_t                   q_head,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [kmst_pkg::VID_W-1:0]       tree_source,
	output logic [kmst_pkg::VID_W-1:0]       tree_target,
	output logic signed [kmst_pkg::WT_W-1:0] tree_weight,
	output logic                             is_empty,
	output logic                             overflowed,
	output logic                             last_result
);
	localparam int EAW  = (EDGES > 1) ? $clog2(EDGES) : 1;
	localparam int ECW  = $clog2(EDGES + 1);
	localparam int VAW  = $clog2(VERTICES);
	localparam int UFW  = VAW + kmst_pkg::RANK_W;
	localparam int ESW  = $bits(kmst_pkg::edge_t);
	localparam int VLIM = (VERTICES < kmst_pkg::VC_MAX) ? VERTICES : kmst_pkg::VC_MAX;

	kmst_pkg::state_t st_q, st_d;

	kmst_pkg::cmd_t cmd_q;
	logic [ECW-1:0] cnt_q;
	logic [EAW-1:0] j_q;
	logic [ECW-1:0] k_q;
	logic [VAW-1:0] v_q;
	logic [VAW-1:0] addr_q;
	logic [VAW-1:0] a_q, b_q;
	logic [kmst_pkg::RANK_W-1:0] ra_q, rb_q;
	logic [kmst_pkg::TAKEN_W-1:0] taken_q, need_q;
	kmst_pkg::edge_t e_q;
	kmst_pkg::edge_t pend_q;
	logic pend_v_q;
	logic out_valid_q;
	kmst_pkg::edge_t out_e_q;
	logic out_empty_q, out_ovf_q, out_last_q;

	// edge store ports
	logic           es_we;
	logic [EAW-1:0] es_waddr, es_raddr;
	kmst_pkg::edge_t es_wdata, es_rdata;
	logic [ESW-1:0] es_rbits;
	// union-find table ports: {parent, rank}
	logic           uf_we;
	logic [VAW-1:0] uf_waddr, uf_raddr;
	logic [UFW-1:0] uf_wdata, uf_rdata;
	logic [VAW-1:0] uf_par;
	logic [kmst_pkg::RANK_W-1:0] uf_rank;

	logic out_free;
	logic e_in_range;
	logic ins_shift;
	logic [kmst_pkg::VC_W-1:0] vc_clamp;
	logic rank_bump;

	assign es_rdata = kmst_pkg::edge_t'(es_rbits);
	assign uf_par   = uf_rdata[UFW-1:kmst_pkg::RANK_W];
	assign uf_rank  = uf_rdata[kmst_pkg::RANK_W-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign e_in_range = (int'(es_rdata.src) < VERTICES) && (int'(es_rdata.dst) < VERTICES);
	assign ins_shift  = (es_rdata.wt > cmd_q.e.wt);
	assign rank_bump  = (ra_q == rb_q) && (ra_q != kmst_pkg::RANK_W'(kmst_pkg::RANK_MAX));

	always_comb begin
		if (vertex_count == '0) begin
			vc_clamp = kmst_pkg::VC_W'(1);
		end else if (int'(vertex_count) > VLIM) begin
			vc_clamp = kmst_pkg::VC_W'(VLIM);
		end else begin
			vc_clamp = vertex_count;
		end
	end

	kmst_ram #(.W(ESW), .D(EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (es_we),
		.waddr (es_waddr),
		.wdata (es_wdata),
		.raddr (es_raddr),
		.rdata (es_rbits)
	);

	kmst_ram #(.W(UFW), .D(VERTICES)) u_uf_ram (
		.clk   (clk),
		.we    (uf_we),
		.waddr (uf_waddr),
		.wdata (uf_wdata),
		.raddr (uf_raddr),
		.rdata (uf_rdata)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			kmst_pkg::ST_IDLE: begin
				if (!q_empty) begin
					if (q_head.store) begin
						st_d = kmst_pkg::ST_INS_RD;
					end else if (q_head.run) begin
						st_d = kmst_pkg::ST_CLR;
					end
				end
			end
			kmst_pkg::ST_INS_RD: begin
				if (j_q == '0) begin
					st_d = cmd_q.run ? kmst_pkg::ST_CLR : kmst_pkg::ST_IDLE;
				end else begin
					st_d = kmst_pkg::ST_INS_CMP;
				end
			end
			kmst_pkg::ST_INS_CMP: begin
				if (ins_shift) begin
					st_d = kmst_pkg::ST_INS_RD;
				end else begin
					st_d = cmd_q.run ? kmst_pkg::ST_CLR : kmst_pkg::ST_IDLE;
				end
			end
			kmst_pkg::ST_CLR: begin
				if (v_q == VAW'(VERTICES - 1)) begin
					st_d = kmst_pkg::ST_SCAN;
				end
			end
			kmst_pkg::ST_SCAN: begin
				if (k_q == cnt_q || taken_q == need_q) begin
					st_d = kmst_pkg::ST_FLUSH;
				end else begin
					st_d = kmst_pkg::ST_EDGE;
				end
			end
			kmst_pkg::ST_EDGE: begin
				st_d = e_in_range ? kmst_pkg::ST_FIND_A : kmst_pkg::ST_SCAN;
			end
			kmst_pkg::ST_FIND_A: begin
				if (uf_par == addr_q) begin
					st_d = kmst_pkg::ST_FIND_B;
				end
			end
			kmst_pkg::ST_FIND_B: begin
				if (uf_par == addr_q) begin
					st_d = (addr_q == a_q) ? kmst_pkg::ST_SCAN : kmst_pkg::ST_JOIN;
				end
			end
			kmst_pkg::ST_JOIN: begin
				if (!pend_v_q || out_free) begin
					st_d = rank_bump ? kmst_pkg::ST_JOIN2 : kmst_pkg::ST_SCAN;
				end
			end
			kmst_pkg::ST_JOIN2: begin
				st_d = kmst_pkg::ST_SCAN;
			end
			kmst_pkg::ST_FLUSH: begin
				if (out_free) begin
					st_d = kmst_pkg::ST_IDLE;
				end
			end
			default: st_d = kmst_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		q_pop    = 1'b0;
		es_we    = 1'b0;
		es_waddr = j_q;
		es_wdata = cmd_q.e;
		es_raddr = j_q - EAW'(1);
		uf_we    = 1'b0;
		uf_waddr = v_q;
		uf_wdata = {v_q, kmst_pkg::RANK_W'(0)};
		uf_raddr = addr_q;
		unique case (st_q)
			kmst_pkg::ST_IDLE: begin
				q_pop = !q_empty;
			end
			kmst_pkg::ST_INS_RD: begin
				es_we = (j_q == '0);
			end
			kmst_pkg::ST_INS_CMP: begin
				es_we    = 1'b1;
				es_wdata = ins_shift ? es_rdata : cmd_q.e;
			end
			kmst_pkg::ST_CLR: begin
				uf_we = 1'b1;
			end
			kmst_pkg::ST_SCAN: begin
				es_raddr = k_q[EAW-1:0];
			end
			kmst_pkg::ST_EDGE: begin
				uf_raddr = VAW'(es_rdata.src);
			end
			kmst_pkg::ST_FIND_A: begin
				uf_raddr = (uf_par == addr_q) ? VAW'(e_q.dst) : uf_par;
			end
			kmst_pkg::ST_FIND_B: begin
				uf_raddr = uf_par;
			end
			kmst_pkg::ST_JOIN: begin
				uf_we = !pend_v_q || out_free;
				if (ra_q < rb_q) begin
					uf_waddr = a_q;
					uf_wdata = {b_q, ra_q};
				end else begin
					uf_waddr = b_q;
					uf_wdata = {a_q, rb_q};
				end
			end
			kmst_pkg::ST_JOIN2: begin
				uf_we    = 1'b1;
				uf_waddr = a_q;
				uf_wdata = {a_q, ra_q + kmst_pkg::RANK_W'(1)};
			end
			kmst_pkg::ST_FLUSH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= kmst_pkg::ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			v_q         <= '0;
			taken_q     <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				kmst_pkg::ST_INS_RD: begin
					if (j_q == '0) begin
						cnt_q <= cnt_q + ECW'(1);
					end
				end
				kmst_pkg::ST_INS_CMP: begin
					if (!ins_shift) begin
						cnt_q <= cnt_q + ECW'(1);
					end
				end
				kmst_pkg::ST_CLR: begin
					v_q <= v_q + VAW'(1);
				end
				kmst_pkg::ST_EDGE: begin
					if (!e_in_range) begin
						k_q <= k_q + ECW'(1);
					end
				end
				kmst_pkg::ST_FIND_B: begin
					if (uf_par == addr_q && addr_q == a_q) begin
						k_q <= k_q + ECW'(1);
					end
				end
				kmst_pkg::ST_JOIN: begin
					if (!pend_v_q || out_free) begin
						k_q      <= k_q + ECW'(1);
						taken_q  <= taken_q + kmst_pkg::TAKEN_W'(1);
						pend_v_q <= 1'b1;
						if (pend_v_q) begin
							out_valid_q <= 1'b1;
						end
					end
				end
				kmst_pkg::ST_FLUSH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						pend_v_q    <= 1'b0;
						cnt_q       <= '0;
						k_q         <= '0;
						v_q         <= '0;
						taken_q     <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (st_q)
			kmst_pkg::ST_IDLE: begin
				cmd_q  <= q_head;
				j_q    <= cnt_q[EAW-1:0];
				need_q <= kmst_pkg::TAKEN_W'(vc_clamp - kmst_pkg::VC_W'(1));
			end
			kmst_pkg::ST_INS_CMP: begin
				if (ins_shift) begin
					j_q <= j_q - EAW'(1);
				end
			end
			kmst_pkg::ST_EDGE: begin
				e_q    <= es_rdata;
				addr_q <= VAW'(es_rdata.src);
			end
			kmst_pkg::ST_FIND_A: begin
				if (uf_par == addr_q) begin
					a_q    <= addr_q;
					ra_q   <= uf_rank;
					addr_q <= VAW'(e_q.dst);
				end else begin
					addr_q <= uf_par;
				end
			end
			kmst_pkg::ST_FIND_B: begin
				if (uf_par == addr_q) begin
					b_q  <= addr_q;
					rb_q <= uf_rank;
				end else begin
					addr_q <= uf_par;
				end
			end
			kmst_pkg::ST_JOIN: begin
				if (!pend_v_q || out_free) begin
					pend_q <= e_q;
					if (pend_v_q) begin
						out_e_q     <= pend_q;
						out_empty_q <= 1'b0;
						out_ovf_q   <= cmd_q.ovf;
						out_last_q  <= 1'b0;
					end
				end
			end
			kmst_pkg::ST_FLUSH: begin
				if (out_free) begin
					out_e_q     <= pend_v_q ? pend_q : '0;
					out_empty_q <= !pend_v_q;
					out_ovf_q   <= cmd_q.ovf;
					out_last_q  <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign tree_source = out_e_q.src;
	assign tree_target = out_e_q.dst;
	assign tree_weight = out_e_q.wt;
	assign is_empty    = out_empty_q;
	assign overflowed  = out_ovf_q;
	assign last_result = out_last_q;

	`KMST_ASSERT(a_cnt_bound, int'(cnt_q) <= EDGES, "edge count beyond store depth")
	`KMST_ASSERT(a_taken_bound, (st_q == kmst_pkg::ST_IDLE) || (taken_q <= need_q), "too many tree edges")
	`KMST_ASSERT(a_idle_no_pend, (st_q != kmst_pkg::ST_IDLE) || !pend_v_q, "pending edge left after run")
	`KMST_ASSERT_NEXT(a_flush_emit, (st_q == kmst_pkg::ST_FLUSH) && out_free, out_valid_q && out_last_q, "run ended without final word")
endmodule

@@ rtl/kruskal_minimum_spanning_tree.sv @@
// Kruskal minimum spanning tree: edge words in, tree edge words out.
// Channels: in (edge_source, edge_target, edge_weight, last_edge) with in_valid/in_ready;
// out (tree_source, tree_target, tree_weight, is_empty, overflowed, last_result) with
// out_valid/out_ready; cfg_data (vertex_count) with cfg_valid/cfg_ready, always ready.
// Each edge word that fits is inserted into a weight-sorted store as it arrives; every
// stored edge that is heavier than the new one is moved up by one place (edge RAM read,
// then write). A two-entry queue lets the input side run ahead of the insertion.
// The word flagged last_edge starts the run: the union-find table is cleared, then each
// scanned edge has the roots of its two ends found by following parent links, and edges
// whose roots differ are joined by rank. Tree edges appear in ascending weight order; the
// final one carries last_result. A run with no tree edge gives one word with is_empty set.
// Edges beyond EDGES are dropped and flagged in overflowed for that graph.
// Reset clears all control state and sets vertex_count to 16; the edge store needs no
// clearing. When out_ready is low, the result register holds, and a join or the final flush that must emit waits.
module kruskal_minimum_spanning_tree #(
	parameter int VERTICES = kmst_pkg::VERTICES_DEF,
	parameter int EDGES    = kmst_pkg::EDGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kmst_pkg::VC_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [kmst_pkg::VID_W-1:0]       edge_source,
	input  logic [kmst_pkg::VID_W-1:0]       edge_target,
	input  logic signed [kmst_pkg::WT_W-1:0] edge_weight,
	input  logic                             last_edge,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [kmst_pkg::VID_W-1:0]       tree_source,
	output logic [kmst_pkg::VID_W-1:0]       tree_target,
	output logic signed [kmst_pkg::WT_W-1:0] tree_weight,
	output logic                             is_empty,
	output logic                             overflowed,
	output logic                             last_result
);
	logic [kmst_pkg::VC_W-1:0] vertex_count_q;
	logic           q_full, q_empty, q_push, q_pop;
	kmst_pkg::cmd_t q_data, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= kmst_pkg::VC_W'(kmst_pkg::VC_RESET);
		end else if (cfg_valid) begin
			vertex_count_q <= cfg_data;
		end
	end

	kmst_front #(.EDGES(EDGES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.edge_source (edge_source),
		.edge_target (edge_target),
		.edge_weight (edge_weight),
		.last_edge   (last_edge),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	kmst_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	kmst_back #(.VERTICES(VERTICES), .EDGES(EDGES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_count (vertex_count_q),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tree_source  (tree_source),
		.tree_target  (tree_target),
		.tree_weight  (tree_weight),
		.is_empty     (is_empty),
		.overflowed   (overflowed),
		.last_result  (last_result)
	);
endmodule
